// ----- rtl/core/drat_proof_byte_encoder_core_defines.svh -----
// Assertion macros used by the checker of this block.
`ifndef DRAT_PROOF_BYTE_ENCODER_CORE_DEFINES_SVH
`define DRAT_PROOF_BYTE_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dpe_pkg.sv -----
package dpe_pkg;

  localparam int LIT_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int CFG_IDX_W  = 1;

  // item kinds
  localparam logic [1:0] KIND_ADD_START = 2'd0;
  localparam logic [1:0] KIND_DEL_START = 2'd1;
  localparam logic [1:0] KIND_LITERAL   = 2'd2;
  localparam logic [1:0] KIND_END       = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACING     = 1'd1;

  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] VINT_MASK = 8'h7f;
  localparam logic [7:0] VINT_CONT = 8'h80;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [LIT_W-1:0] literal_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] added_total;
    logic [31:0] deleted_total;
  } result_t;

  typedef struct packed {
    logic load;    // take a new magnitude
    logic conv;    // one shift-and-correct step
    logic dshift;  // drop the leading digit
  } bcd_cmd_t;

endpackage

// ----- rtl/core/dpe_bcd.sv -----
// Binary to decimal by shift-and-add-3, one bit per step; digits are then
// read out from the top nibble.
module dpe_bcd
  import dpe_pkg::*;
(
  input  logic             clk,
  input  bcd_cmd_t         cmd,
  input  logic [LIT_W-1:0] mag,
  output logic [3:0]       top_digit
);

  logic [LIT_W-1:0]        bin;
  logic [4*BCD_DIGITS-1:0] bcd;
  logic [4*BCD_DIGITS-1:0] adj;

  always_comb begin
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= mag;
      bcd <= '0;
    end else if (cmd.conv) begin
      {bcd, bin} <= {adj[4*BCD_DIGITS-2:0], bin, 1'b0};
    end else if (cmd.dshift) begin
      bcd <= {bcd[4*BCD_DIGITS-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[4*BCD_DIGITS-1 -: 4];

endmodule

// ----- rtl/core/drat_proof_byte_encoder_core.sv -----
// Output: one byte per cycle from a registered output stage unless
// result_stall holds it. Binary: start/end one byte, literal 1-5 bytes
// (one 7-bit shift per byte). Text: add start none, delete start and
// end 2 bytes; literal: shift-and-add-3, leading-zero skip, sign, digits, space.
// Next item is taken once the last byte of the current one is registered.
// Synchronous reset: binary mode and tracing on, counters cleared.
module drat_proof_byte_encoder_core
  import dpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_FIXED, S_VARINT, S_CONV, S_SKIP, S_SIGN, S_DIGITS
  } state_t;

  state_t      state;
  logic        binary_mode;
  logic        tracing_enabled;
  logic [31:0] added_clauses;
  logic [31:0] deleted_clauses;
  logic        clause_is_deletion;

  logic [7:0]  fix0;
  logic [7:0]  fix1;
  logic        fix_two;
  logic [32:0] vbits;
  logic        neg;
  logic [4:0]  cnt;
  logic [3:0]  dcnt;

  logic             accept;
  logic             take;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             lit_neg;
  logic [LIT_W-1:0] lit_u;
  logic [LIT_W-1:0] lit_mag;
  logic             vmore;
  logic [3:0]       top_digit;
  bcd_cmd_t         bcd_cmd;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign take       = !result_valid || !result_stall;

  assign lit_u   = item.literal_value;
  assign lit_neg = lit_u[LIT_W-1];
  assign lit_mag = lit_neg ? (~lit_u + 32'd1) : lit_u;
  assign vmore   = |vbits[32:7];

  always_comb begin
    bcd_cmd.load   = accept && tracing_enabled && !binary_mode && (item.kind == KIND_LITERAL);
    bcd_cmd.conv   = (state == S_CONV);
    bcd_cmd.dshift = ((state == S_SKIP) && (top_digit == 4'd0) && (dcnt > 4'd1)) ||
                     ((state == S_DIGITS) && take);
  end

  always_comb begin
    emit      = 1'b0;
    emit_byte = fix0;
    emit_last = 1'b0;
    case (state)
      S_FIXED: begin
        emit      = take;
        emit_last = !fix_two;
      end
      S_VARINT: begin
        emit      = take;
        emit_byte = (vbits[7:0] & VINT_MASK) | (vmore ? VINT_CONT : CH_NUL);
        emit_last = !vmore;
      end
      S_SIGN: begin
        emit      = take;
        emit_byte = CH_MINUS;
      end
      S_DIGITS: begin
        emit      = take;
        emit_byte = CH_ZERO + {4'd0, top_digit};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  dpe_bcd u_bcd (
    .clk       (clk),
    .cmd       (bcd_cmd),
    .mag       (lit_mag),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      result_valid       <= 1'b0;
      binary_mode        <= 1'b1;
      tracing_enabled    <= 1'b1;
      added_clauses      <= '0;
      deleted_clauses    <= '0;
      clause_is_deletion <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_BINARY_MODE: binary_mode     <= cfg_data[0];
          REG_TRACING:     tracing_enabled <= cfg_data[0];
          default: ;
        endcase
      end

      if (take) begin
        result_valid <= emit;
      end
      if (emit) begin
        result.out_byte      <= emit_byte;
        result.last          <= emit_last;
        result.added_total   <= added_clauses;
        result.deleted_total <= deleted_clauses;
      end

      case (state)
        S_IDLE: begin
          if (accept && tracing_enabled) begin
            fix_two <= 1'b0;
            case (item.kind)
              KIND_ADD_START: begin
                clause_is_deletion <= 1'b0;
                fix0               <= CH_A;
                if (binary_mode) begin
                  state <= S_FIXED;
                end
              end
              KIND_DEL_START: begin
                clause_is_deletion <= 1'b1;
                fix0               <= CH_D;
                fix1               <= CH_SPACE;
                fix_two            <= !binary_mode;
                state              <= S_FIXED;
              end
              KIND_LITERAL: begin
                vbits <= {lit_mag, lit_neg};
                neg   <= lit_neg;
                cnt   <= '0;
                state <= binary_mode ? S_VARINT : S_CONV;
              end
              KIND_END: begin
                fix0    <= binary_mode ? CH_NUL : CH_ZERO;
                fix1    <= CH_NL;
                fix_two <= !binary_mode;
                state   <= S_FIXED;
                if (clause_is_deletion) begin
                  if (deleted_clauses != '1) begin
                    deleted_clauses <= deleted_clauses + 32'd1;
                  end
                end else if (added_clauses != '1) begin
                  added_clauses <= added_clauses + 32'd1;
                end
              end
              default: ;
            endcase
          end
        end
        S_FIXED: begin
          if (take) begin
            if (fix_two) begin
              fix0    <= fix1;
              fix_two <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_VARINT: begin
          if (take) begin
            vbits <= vbits >> 7;
            if (!vmore) begin
              state <= S_IDLE;
            end
          end
        end
        S_CONV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            dcnt  <= 4'(BCD_DIGITS);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (bcd_cmd.dshift) begin
            dcnt <= dcnt - 4'd1;
          end else begin
            state <= neg ? S_SIGN : S_DIGITS;
          end
        end
        S_SIGN: begin
          if (take) begin
            state <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (take) begin
            dcnt <= dcnt - 4'd1;
            if (dcnt == 4'd1) begin
              fix0    <= CH_SPACE;
              fix_two <= 1'b0;
              state   <= S_FIXED;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/dpe_checker.sv -----
`include "drat_proof_byte_encoder_core_defines.svh"

module dpe_checker
  import dpe_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic res_xfer;
  assign res_xfer = result_valid && !result_stall;

  // a stalled byte stays put
  `DPE_ASSERT_NEXT(a_res_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // more bytes of the same item pending, so no new item may be taken
  `DPE_ASSERT_IMP(a_busy_mid_item, clk, rst, result_valid && !result.last, item_stall, "input open mid-item")

  // bytes of one item carry the same totals
  `DPE_ASSERT_NEXT(a_totals_in_item, clk, rst, res_xfer && !result.last, !result_valid || (result.added_total == $past(result.added_total) && result.deleted_total == $past(result.deleted_total)), "totals changed within an item")

  // counters never go backwards
  `DPE_ASSERT_NEXT(a_totals_mono, clk, rst, result_valid, !result_valid || (result.added_total >= $past(result.added_total) && result.deleted_total >= $past(result.deleted_total)), "totals decreased")

endmodule

bind drat_proof_byte_encoder_core dpe_checker u_dpe_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
